// ----- rtl/dq_pkg.sv -----
package dq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic              apply;
    mode_t             mode;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  fill_nxt;
    logic [WORD_W-1:0] value;
  } dq_ctrl_t;

endpackage

// ----- rtl/dq_cell.sv -----
module dq_cell (
  input  logic                         clk,
  input  logic [dq_pkg::IDX_W-1:0]     cell_idx,
  input  dq_pkg::dq_ctrl_t             ctrl,
  input  logic [dq_pkg::WORD_W-1:0]    left_data,
  input  logic [dq_pkg::WORD_W-1:0]    right_data,
  output logic [dq_pkg::WORD_W-1:0]    data_r,
  output logic [dq_pkg::WORD_W-1:0]    data_nxt,
  output logic                         rear_hit
);

  logic [dq_pkg::CNT_W-1:0] pos;

  assign pos = dq_pkg::CNT_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.apply) begin
      unique case (ctrl.mode)
        dq_pkg::MODE_PUSH_FRONT: data_nxt = left_data;
        dq_pkg::MODE_PUSH_REAR: begin
          if (pos == ctrl.fill) begin
            data_nxt = ctrl.value;
          end
        end
        dq_pkg::MODE_POP_FRONT:  data_nxt = right_data;
        dq_pkg::MODE_POP_REAR:   data_nxt = data_r;
        default:                 data_nxt = data_r;
      endcase
    end
  end

  // This cell holds the rear element once the transaction has been applied.
  assign rear_hit = (pos == (ctrl.fill_nxt - dq_pkg::CNT_W'(1)));

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// A transaction's result is registered and appears in the cycle after it is accepted.
// One transaction per cycle unless a held result stalls on out_tready; every
// cell of the row shifts, loads or holds in the same cycle, so no operation
// takes more than one pass. Reset (rst_n low, synchronous) empties the queue
// and drops any pending result; the cell contents are not cleared.
module double_ended_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] front_value, [63:32] rear_value,
                                  // [68:64] fill_count, [70:69] status, [71] zero
);

  localparam int unsigned N = dq_pkg::DEPTH;
  localparam int unsigned W = dq_pkg::WORD_W;

  logic                     accept;
  dq_pkg::mode_t            mode;
  dq_pkg::status_t          status;
  logic                     is_push;
  logic [dq_pkg::CNT_W-1:0] fill_r;
  logic [dq_pkg::CNT_W-1:0] fill_nxt;
  dq_pkg::dq_ctrl_t         ctrl;

  logic [W-1:0] cell_data [N];
  logic [W-1:0] cell_nxt  [N];
  logic [N-1:0] rear_hit;

  logic [W-1:0]             front_nxt;
  logic [W-1:0]             rear_nxt;
  logic [W-1:0]             front_r;
  logic [W-1:0]             rear_r;
  logic [dq_pkg::CNT_W-1:0] out_fill_r;
  dq_pkg::status_t          status_r;
  logic                     out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign mode      = dq_pkg::mode_t'(in_tuser);
  assign is_push   = (mode == dq_pkg::MODE_PUSH_FRONT) || (mode == dq_pkg::MODE_PUSH_REAR);

  always_comb begin
    status   = dq_pkg::ST_OK;
    fill_nxt = fill_r;
    if (is_push) begin
      if (fill_r == dq_pkg::CNT_W'(N)) begin
        status = dq_pkg::ST_OVERFLOW;
      end else begin
        fill_nxt = fill_r + dq_pkg::CNT_W'(1);
      end
    end else begin
      if (fill_r == '0) begin
        status = dq_pkg::ST_UNDERFLOW;
      end else begin
        fill_nxt = fill_r - dq_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    ctrl.apply    = accept && (status == dq_pkg::ST_OK);
    ctrl.mode     = mode;
    ctrl.fill     = fill_r;
    ctrl.fill_nxt = fill_nxt;
    ctrl.value    = in_tdata;
  end

  // Cell 0 always holds the front element; a push at the front shifts the row
  // towards the rear and a pop from the front shifts it back.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left_in;
    logic [W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = in_tdata;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .cell_idx   (dq_pkg::IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_in),
      .right_data (right_in),
      .data_r     (cell_data[i]),
      .data_nxt   (cell_nxt[i]),
      .rear_hit   (rear_hit[i])
    );
  end

  always_comb begin
    rear_nxt = '0;
    for (int k = 0; k < N; k++) begin
      rear_nxt = rear_nxt | (cell_nxt[k] & {W{rear_hit[k]}});
    end
    front_nxt = cell_nxt[0];
    if (fill_nxt == '0) begin
      front_nxt = dq_pkg::EMPTY_WORD;
      rear_nxt  = dq_pkg::EMPTY_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_r    <= front_nxt;
      rear_r     <= rear_nxt;
      out_fill_r <= fill_nxt;
      status_r   <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, status_r, out_fill_r, rear_r, front_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= dq_pkg::CNT_W'(N))
    else $error("fill count beyond depth");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == dq_pkg::ST_UNDERFLOW) |-> (out_fill_r == '0))
    else $error("underflow reported on a non-empty queue");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == dq_pkg::ST_OVERFLOW) |-> (out_fill_r == dq_pkg::CNT_W'(N)))
    else $error("overflow reported on a queue that is not full");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_fill_r == '0) |->
      (front_r == dq_pkg::EMPTY_WORD) && (rear_r == dq_pkg::EMPTY_WORD))
    else $error("empty queue does not report all-ones words");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(fill_r))
    else $error("stalled result lost or state changed under stall");

endmodule

// ----- sim/double_ended_queue_core_tb.sv -----
module double_ended_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dq_pkg::mode_t             mode;
    logic [dq_pkg::WORD_W-1:0] value;
  } deq_op_t;

  typedef struct packed {
    logic [dq_pkg::WORD_W-1:0] front_value;
    logic [dq_pkg::WORD_W-1:0] rear_value;
    logic [dq_pkg::CNT_W-1:0]  fill_count;
    dq_pkg::status_t           status;
  } deq_ends_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [31:0] front_value, [63:32] rear_value,
                                // [68:64] fill_count, [70:69] status, [71] zero

  deq_op_t   ops_to_send[$];
  deq_ends_t ends_expected[$];

  // Shadow model of the queue, kept by the predictor as a ring.
  logic [dq_pkg::WORD_W-1:0] ring_mem [dq_pkg::DEPTH];
  int unsigned               head_ptr = 0;
  int unsigned               held = 0;

  int  mismatch_cnt = 0;
  int  accepted_ops = 0;
  int  total_ops = 0;
  int  in_gap = 0;
  int  in_calm = 0;
  int  out_gap = 0;
  int  out_calm = 0;
  logic in_fire = 1'b0;

  double_ended_queue_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Mostly short pauses, a few long ones, and now and then a calm stretch with none.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [dq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return dq_pkg::EMPTY_WORD;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(dq_pkg::mode_t m, logic [dq_pkg::WORD_W-1:0] v);
    deq_op_t op;
    op.mode  = m;
    op.value = v;
    ops_to_send.push_back(op);
    total_ops++;
  endtask

  // Applies one operation to the shadow ring and records the result it should give.
  task automatic deque_apply_op(dq_pkg::mode_t m, logic [dq_pkg::WORD_W-1:0] v);
    deq_ends_t res;
    res.status = dq_pkg::ST_OK;
    if (m == dq_pkg::MODE_PUSH_FRONT || m == dq_pkg::MODE_PUSH_REAR) begin
      if (held >= dq_pkg::DEPTH) begin
        res.status = dq_pkg::ST_OVERFLOW;
      end else if (m == dq_pkg::MODE_PUSH_FRONT) begin
        head_ptr = (head_ptr + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
        ring_mem[head_ptr] = v;
        held++;
      end else begin
        ring_mem[(head_ptr + held) % dq_pkg::DEPTH] = v;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = dq_pkg::ST_UNDERFLOW;
      end else begin
        if (m == dq_pkg::MODE_POP_FRONT) head_ptr = (head_ptr + 1) % dq_pkg::DEPTH;
        held--;
      end
    end
    if (held == 0) begin
      res.front_value = dq_pkg::EMPTY_WORD;
      res.rear_value  = dq_pkg::EMPTY_WORD;
    end else begin
      res.front_value = ring_mem[head_ptr];
      res.rear_value  = ring_mem[(head_ptr + held - 1) % dq_pkg::DEPTH];
    end
    res.fill_count = held[dq_pkg::CNT_W-1:0];
    ends_expected.push_back(res);
  endtask

  // A transaction held by the driver is released only once it has been accepted.
  always @(negedge clk) begin : drive_ops
    deq_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (ops_to_send.size() > 0) begin
        op = ops_to_send.pop_front();
        in_tdata  <= op.value;
        in_tuser  <= op.mode;
        in_tvalid <= 1'b1;
        in_gap = draw_gap(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) out_gap = draw_gap(out_calm);
    end
  end

  always @(posedge clk) begin : watch_ends
    deq_ends_t want;
    deq_ends_t got;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      // Predict first so that a result at the same edge would still find its expectation.
      if (in_tvalid && in_tready) begin
        deque_apply_op(dq_pkg::mode_t'(in_tuser), in_tdata);
        accepted_ops++;
      end
      if (out_tvalid && out_tready) begin
        got.front_value = out_tdata[31:0];
        got.rear_value  = out_tdata[63:32];
        got.fill_count  = out_tdata[68:64];
        got.status      = dq_pkg::status_t'(out_tdata[70:69]);
        if (ends_expected.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          mismatch_cnt++;
        end else begin
          want = ends_expected.pop_front();
          if (got.front_value !== want.front_value) begin
            $error("front_value: expected %h, actual %h", want.front_value, got.front_value);
            mismatch_cnt++;
          end
          if (got.rear_value !== want.rear_value) begin
            $error("rear_value: expected %h, actual %h", want.rear_value, got.rear_value);
            mismatch_cnt++;
          end
          if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
            mismatch_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_cnt++;
          end
          if (out_tdata[71] !== 1'b0) begin
            $error("pad bit: expected 0, actual %b", out_tdata[71]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("double_ended_queue_core verification failed");
    $finish;
  end

  initial begin : main_seq
    int push_pct;
    int phase_len;
    dq_pkg::mode_t m;

    // Underflow from both ends, extreme values, a stored all-ones word.
    queue_op(dq_pkg::MODE_POP_FRONT, 32'h1234_5678);
    queue_op(dq_pkg::MODE_POP_REAR, '0);
    queue_op(dq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
    queue_op(dq_pkg::MODE_PUSH_REAR, 32'h7FFF_FFFF);
    queue_op(dq_pkg::MODE_PUSH_FRONT, dq_pkg::EMPTY_WORD);
    queue_op(dq_pkg::MODE_POP_REAR, '0);
    queue_op(dq_pkg::MODE_POP_FRONT, dq_pkg::EMPTY_WORD);
    queue_op(dq_pkg::MODE_POP_FRONT, '0);
    // Fill to the brim from alternating ends, then overflow at each end.
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      queue_op((i % 2) ? dq_pkg::MODE_PUSH_REAR : dq_pkg::MODE_PUSH_FRONT, pick_word());
    end
    queue_op(dq_pkg::MODE_PUSH_FRONT, 32'hA5A5_A5A5);
    queue_op(dq_pkg::MODE_PUSH_REAR, 32'h5A5A_5A5A);

    // Random phases leaning towards filling, draining or balance.
    while (total_ops < 526) begin
      case ($urandom_range(0, 4))
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 50;
        3: push_pct = 70;
        default: push_pct = 30;
      endcase
      phase_len = $urandom_range(20, 60);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          m = $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_REAR : dq_pkg::MODE_PUSH_FRONT;
        end else begin
          m = $urandom_range(0, 1) ? dq_pkg::MODE_POP_REAR : dq_pkg::MODE_POP_FRONT;
        end
        queue_op(m, pick_word());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (accepted_ops == total_ops);
    wait (ends_expected.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("double_ended_queue_core verification clean");
    end else begin
      $display("double_ended_queue_core verification failed");
    end
    $finish;
  end

endmodule
